>>> src/life_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_pkg
// Shared types and constants of the B3/S23 cellular automaton step core.
// ----------------------------------------------------------------------------
package life_pkg;

  // Default grid capacity
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int COORD_W = 6;
  localparam int LIVE_W  = 13;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NBR_W   = 4;

  // Rule constants
  localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_LOW = 4'd2;
  localparam int COUNT_MAX = 8191;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               alive_in;
  } cmd_t;

  typedef struct packed {
    logic              alive_out;
    logic              stable;
    logic [LIVE_W-1:0] live_count;
  } result_t;

endpackage

>>> src/life_cellular_automaton_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_core
// Game of Life (B3/S23) engine over a banked row-word memory, dead borders.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with cmd; the beat is taken on a clock edge
//   where busy is low. Each beat yields exactly one result beat on result,
//   marked by a one-cycle done strobe; the receiver cannot stall it.
//   Config port: cfg_we/cfg_index/cfg_data write row_count or col_count
//   at once; write only while the core is idle.
// Sequencing:
//   Write, read and the unused mode: one memory read at the accepting
//   edge, then ST_ACCESS, where a write does the modify/write-back and the
//   result beat is registered; busy is low while that beat is on the ports.
//   Advance: busy stays high through the sweep and the drain state, which
//   registers the result beat; no new command is taken before then. The sweep
//   reads one row word of the current bank per cycle and writes the next
//   generation row into the other bank; a popcount stage follows the sweep.
// Reset:
//   rst clears control state, then a clearing pass writes bank zero dead,
//   one row per cycle, over all MAX_ROWS rows with busy high.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step_core
  import life_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int RAW   = $clog2(MAX_ROWS);
  localparam int CAW   = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int SW    = $clog2(MAX_ROWS + 2);
  localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_ACCESS = 3'd2;
  localparam logic [2:0] ST_SWEEP  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  // Cell memory: two banks of row words
  logic [MAX_COLS-1:0] mem [0:1][0:MAX_ROWS-1];
  logic [MAX_COLS-1:0] rd_data;

  logic [2:0]          state;
  logic                bank;
  logic [CFG_W-1:0]    row_count;
  logic [CFG_W-1:0]    col_count;
  logic [RAW-1:0]      clr_cnt;
  logic [SW-1:0]       sweep_cnt;
  cmd_t                cmd_q;
  logic [MAX_COLS-1:0] mid_q;
  logic [MAX_COLS-1:0] bot_q;
  logic [MAX_COLS-1:0] pop_row;
  logic                pop_vld;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                changed;

  logic [RCW-1:0]      eff_rows;
  logic [CCW-1:0]      eff_cols;
  logic [MAX_COLS-1:0] col_mask;
  logic                accept;
  logic                cell_ok;

  logic                mem_re;
  logic                rd_bank;
  logic [RAW-1:0]      rd_row;
  logic                mem_we;
  logic                wr_bank;
  logic [RAW-1:0]      wr_row;
  logic [MAX_COLS-1:0] wr_word;

  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS-1:0] new_row;
  logic                row_ok;
  logic                sweep_wr;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Clamp the grid size registers into the usable range
  always_comb begin
    if (row_count == '0) begin
      eff_rows = RCW'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = RCW'(row_count);
    end
    if (col_count == '0) begin
      eff_cols = CCW'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(col_count);
    end
  end

  // Columns in use
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (j < int'(eff_cols));
    end
  end

  assign cell_ok = (int'(cmd_q.row) < int'(eff_rows)) && (int'(cmd_q.col) < int'(eff_cols));

  // Next-generation row from the three-row window
  always_comb begin
    logic [MAX_COLS+1:0] pa;
    logic [MAX_COLS+1:0] pc;
    logic [MAX_COLS+1:0] pb;
    logic [NBR_W-1:0]    n;
    logic [MAX_COLS-1:0] rule;
    if (sweep_cnt >= SW'(1) && (int'(sweep_cnt) - 1) < int'(eff_rows)) begin
      below = rd_data & col_mask;
    end else begin
      below = '0;
    end
    pa = {1'b0, mid_q, 1'b0};
    pc = {1'b0, bot_q, 1'b0};
    pb = {1'b0, below, 1'b0};
    for (int j = 0; j < MAX_COLS; j++) begin
      n = NBR_W'(pa[j]) + NBR_W'(pa[j+1]) + NBR_W'(pa[j+2])
        + NBR_W'(pc[j]) + NBR_W'(pc[j+2])
        + NBR_W'(pb[j]) + NBR_W'(pb[j+1]) + NBR_W'(pb[j+2]);
      rule[j] = (n == BIRTH_COUNT) || (bot_q[j] && (n == SURVIVE_LOW));
    end
    row_ok   = (sweep_cnt >= SW'(2)) && ((int'(sweep_cnt) - 2) < int'(eff_rows));
    new_row  = rule & col_mask & {MAX_COLS{row_ok}};
    sweep_wr = (state == ST_SWEEP) && (sweep_cnt >= SW'(2));
  end

  // Accumulate the popcount of the last written row
  always_comb begin
    logic [CNT_W-1:0] pop;
    pop = '0;
    for (int j = 0; j < MAX_COLS; j++) begin
      pop = pop + CNT_W'(pop_row[j]);
    end
    count_next = pop_vld ? (count + pop) : count;
  end

  // Memory port steering
  always_comb begin
    mem_re  = 1'b0;
    rd_bank = bank;
    rd_row  = RAW'(cmd.row);
    mem_we  = 1'b0;
    wr_bank = bank;
    wr_row  = RAW'(cmd_q.row);
    wr_word = rd_data;
    case (state)
      ST_IDLE: begin
        mem_re = accept;
      end
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_bank = 1'b0;
        wr_row  = clr_cnt;
        wr_word = '0;
      end
      ST_ACCESS: begin
        mem_we = (cmd_q.mode == MODE_WRITE) && cell_ok;
        wr_word[CAW'(cmd_q.col)] = cmd_q.alive_in;
      end
      ST_SWEEP: begin
        mem_re  = (int'(sweep_cnt) < MAX_ROWS);
        rd_row  = RAW'(sweep_cnt);
        mem_we  = sweep_wr;
        wr_bank = !bank;
        wr_row  = RAW'(sweep_cnt - SW'(2));
        wr_word = new_row;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_bank][wr_row] <= wr_word;
    end
    if (mem_re) begin
      rd_data <= mem[rd_bank][rd_row];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RST;
      col_count <= COL_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROW_COUNT) begin
        row_count <= cfg_data;
      end
      if (cfg_index == CFG_COL_COUNT) begin
        col_count <= cfg_data;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      bank    <= 1'b0;
      clr_cnt <= '0;
      done    <= 1'b0;
      pop_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + RAW'(1);
          if (int'(clr_cnt) == MAX_ROWS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            if (cmd.mode == MODE_ADVANCE) begin
              state     <= ST_SWEEP;
              sweep_cnt <= '0;
              mid_q     <= '0;
              bot_q     <= '0;
              count     <= '0;
              changed   <= 1'b0;
              pop_vld   <= 1'b0;
            end else begin
              state <= ST_ACCESS;
            end
          end
        end
        ST_ACCESS: begin
          done   <= 1'b1;
          result <= '{alive_out:  (cmd_q.mode == MODE_READ) && cell_ok
                                  && rd_data[CAW'(cmd_q.col)],
                      stable:     1'b0,
                      live_count: '0};
          state  <= ST_IDLE;
        end
        ST_SWEEP: begin
          // Shift the window and hand the new row to the popcount stage
          if (sweep_cnt >= SW'(1)) begin
            mid_q <= bot_q;
            bot_q <= below;
          end
          pop_vld <= sweep_wr;
          pop_row <= new_row;
          count   <= count_next;
          if (sweep_wr && ((new_row ^ bot_q) != '0)) begin
            changed <= 1'b1;
          end
          sweep_cnt <= sweep_cnt + SW'(1);
          if (int'(sweep_cnt) == MAX_ROWS + 1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          done          <= 1'b1;
          result.alive_out <= 1'b0;
          result.stable <= !changed;
          if (int'(count_next) > COUNT_MAX) begin
            result.live_count <= LIVE_W'(COUNT_MAX);
          end else begin
            result.live_count <= LIVE_W'(count_next);
          end
          pop_vld <= 1'b0;
          bank    <= !bank;
          state   <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
